// File: rtl/core/lrus_pkg.sv
// ----------------------------------------------------------------------------
// lrus_pkg
// Shared widths, result record and helpers for the LRU stack replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrus_pkg;

	localparam int unsigned CFG_W       = 5;
	localparam int unsigned PAGE_W      = 16;
	localparam int unsigned CNT_W       = 16;
	localparam int unsigned IN_DATA_W   = 16;
	localparam int unsigned OUT_DATA_W  = 48;
	localparam int unsigned OUT_USER_W  = 2;

	localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = CFG_W'(16);
	localparam logic [CNT_W-1:0] COUNT_MAX         = {CNT_W{1'b1}};

	// Command from the stream side into the sequencer.
	typedef struct packed {
		logic                start;
		logic                eos;
		logic                take;
	} lrus_cmd_t;

	// Outcome of one reference, held by the sequencer until taken.
	typedef struct packed {
		logic                done;
		logic                idle;
		logic                hit;
		logic                ev_valid;
		logic                eos;
		logic [PAGE_W-1:0]   ev_page;
	} lrus_res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/lrus_ram.sv
// ----------------------------------------------------------------------------
// lrus_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrus_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/lrus_ctrl.sv
// ----------------------------------------------------------------------------
// lrus_ctrl
// Sequencer for search, shift-down and top write over the stack RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module lrus_ctrl #(
	parameter int unsigned MAX_FRAMES = 16,
	parameter int unsigned PAGE_BITS  = 16,
	parameter int unsigned OCC_W      = $clog2(MAX_FRAMES + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lrus_pkg::lrus_cmd_t            cmd,
	input  wire logic [lrus_pkg::IN_DATA_W-1:0] page_in,
	input  wire logic [OCC_W-1:0]               limit,
	output lrus_pkg::lrus_res_t                 res
);

	import lrus_pkg::*;

	localparam int unsigned ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned EXT_W  = PAGE_BITS + PAGE_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_SHIFT  = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t                state_q;
	logic [OCC_W-1:0]      occ_q;
	logic [ADDR_W-1:0]     idx_q;
	logic                  issue_q;
	logic                  cmp_v_s1;
	logic [ADDR_W-1:0]     cmp_idx_s1;
	logic                  sh_v_s1;
	logic [ADDR_W-1:0]     dst_s1;
	logic [PAGE_BITS-1:0]  page_q;
	logic [PAGE_BITS-1:0]  bottom_q;
	logic                  eos_q;
	logic                  hit_q;
	logic                  ev_valid_q;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [PAGE_BITS-1:0]  ram_wdata;
	logic [PAGE_BITS-1:0]  ram_rdata;

	logic [ADDR_W-1:0]     last;
	logic                  match;
	logic                  room;
	logic                  search_miss;
	logic [EXT_W-1:0]      page_ext;
	logic [EXT_W-1:0]      bottom_ext;

	assign last        = ADDR_W'(occ_q - 1'b1);
	assign match       = cmp_v_s1 && (ram_rdata == page_q);
	assign room        = occ_q < limit;
	assign search_miss = !issue_q && !cmp_v_s1;
	assign page_ext    = {{PAGE_BITS{1'b0}}, page_in};
	assign bottom_ext  = {{PAGE_W{1'b0}}, bottom_q};

	lrus_ram #(
		.WIDTH (PAGE_BITS),
		.DEPTH (MAX_FRAMES),
		.AW    (ADDR_W)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Single write port: push on a miss with room, shifted entries, then the top.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = last;
		ram_wdata = page_q;
		case (state_q)
			ST_SEARCH: begin
				if (!match && search_miss && room) begin
					ram_we    = 1'b1;
					ram_waddr = ADDR_W'(occ_q);
				end
			end
			ST_SHIFT: begin
				if (sh_v_s1) begin
					ram_we    = 1'b1;
					ram_waddr = dst_s1;
					ram_wdata = ram_rdata;
				end else if (!issue_q) begin
					ram_we    = 1'b1;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			occ_q      <= '0;
			idx_q      <= '0;
			issue_q    <= 1'b0;
			cmp_v_s1   <= 1'b0;
			cmp_idx_s1 <= '0;
			sh_v_s1    <= 1'b0;
			dst_s1     <= '0;
			eos_q      <= 1'b0;
			hit_q      <= 1'b0;
			ev_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cmp_v_s1 <= 1'b0;
					sh_v_s1  <= 1'b0;
					if (cmd.start) begin
						eos_q      <= cmd.eos;
						hit_q      <= 1'b0;
						ev_valid_q <= 1'b0;
						idx_q      <= '0;
						issue_q    <= (occ_q != '0);
						state_q    <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					cmp_idx_s1 <= idx_q;
					if (match) begin
						// Close the gap above the hit, then rewrite the top.
						hit_q    <= 1'b1;
						idx_q    <= cmp_idx_s1 + 1'b1;
						issue_q  <= (cmp_idx_s1 != last);
						cmp_v_s1 <= 1'b0;
						state_q  <= ST_SHIFT;
					end else begin
						cmp_v_s1 <= issue_q;
						if (issue_q) begin
							if (idx_q == last) begin
								issue_q <= 1'b0;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end else if (search_miss) begin
							if (room) begin
								occ_q   <= occ_q + 1'b1;
								state_q <= ST_DONE;
							end else begin
								ev_valid_q <= 1'b1;
								idx_q      <= ADDR_W'(1);
								issue_q    <= (last != '0);
								state_q    <= ST_SHIFT;
							end
						end
					end
				end
				ST_SHIFT: begin
					sh_v_s1 <= issue_q;
					dst_s1  <= idx_q - 1'b1;
					if (issue_q) begin
						if (idx_q == last) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (!issue_q && !sh_v_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.take) begin
						if (eos_q) begin
							occ_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.start) begin
			page_q <= page_ext[PAGE_BITS-1:0];
		end
		if (state_q == ST_SEARCH && cmp_v_s1 && cmp_idx_s1 == '0) begin
			bottom_q <= ram_rdata;
		end
	end

	always_comb begin
		res.done     = (state_q == ST_DONE);
		res.idle     = (state_q == ST_IDLE);
		res.hit      = hit_q;
		res.ev_valid = ev_valid_q;
		res.eos      = eos_q;
		res.ev_page  = ev_valid_q ? bottom_ext[PAGE_W-1:0] : '0;
	end

endmodule

`default_nettype wire

// File: rtl/core/lru_stack_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_stack_page_replacement
// LRU stack page replacement with saturating hit and fault counters.
// ----------------------------------------------------------------------------
// One page reference is taken at a time and searched for in an ordered stack
// held in a small RAM, bottom entry least recently used. The sequencer reads
// one entry per cycle through a single compare unit; on a hit the entries
// above the match move down one place, on a miss with a free frame the page is
// pushed, otherwise the bottom page is evicted and the stack moves down. The
// page is then written at the top. Every entry move takes one RAM read and one
// RAM write. The input is not ready while a reference is in work; a finished
// result waits in the output register while the next reference is taken. The
// user must write frame_count only while the block is idle; the block itself
// does not enforce this. Zero acts as one frame and values above MAX_FRAMES
// act as MAX_FRAMES. A reference with tlast set returns its result normally,
// then the stack and both counters clear.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_stack_page_replacement #(
	parameter int unsigned MAX_FRAMES = 16,
	parameter int unsigned PAGE_BITS  = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Reference stream.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [lrus_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] page_number
	input  wire logic                            s_tlast,   // end_of_string
	// Result stream.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [lrus_pkg::OUT_DATA_W-1:0]      m_tdata,   // [15:0] evicted_page,
	                                                        // [31:16] fault_count,
	                                                        // [47:32] hit_count
	output logic [lrus_pkg::OUT_USER_W-1:0]      m_tuser,   // [0] hit, [1] evicted_valid
	// frame_count register.
	input  wire logic                            cfg_wr_en,
	input  wire logic [lrus_pkg::CFG_W-1:0]      cfg_wr_data
);

	import lrus_pkg::*;

	localparam int unsigned OCC_W = $clog2(MAX_FRAMES + 1);
	localparam int unsigned LIM_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

	logic [CFG_W-1:0]      frame_count_q;
	logic [CNT_W-1:0]      faults_q;
	logic [CNT_W-1:0]      hits_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [OUT_USER_W-1:0] m_tuser_q;

	logic [LIM_W-1:0]      fc_ext;
	logic [LIM_W-1:0]      lim_wide;
	logic [OCC_W-1:0]      limit;
	lrus_cmd_t             cmd;
	lrus_res_t             res;
	logic                  take;
	logic [CNT_W-1:0]      faults_n;
	logic [CNT_W-1:0]      hits_n;

	// Clamp the frame count into 1..MAX_FRAMES.
	assign fc_ext = LIM_W'(frame_count_q);
	always_comb begin
		if (fc_ext == '0) begin
			lim_wide = LIM_W'(1);
		end else if (fc_ext > LIM_W'(MAX_FRAMES)) begin
			lim_wide = LIM_W'(MAX_FRAMES);
		end else begin
			lim_wide = fc_ext;
		end
	end
	assign limit = OCC_W'(lim_wide);

	// Take a result whenever the output register is empty or drains this cycle.
	assign take = res.done && (!m_tvalid_q || m_tready);

	assign s_tready  = res.idle;
	assign cmd.start = s_tvalid && res.idle;
	assign cmd.eos   = s_tlast;
	assign cmd.take  = take;

	assign faults_n = res.hit ? faults_q : sat_inc(faults_q);
	assign hits_n   = res.hit ? sat_inc(hits_q) : hits_q;

	lrus_ctrl #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.OCC_W      (OCC_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.page_in (s_tdata),
		.limit   (limit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
			faults_q      <= '0;
			hits_q        <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				frame_count_q <= cfg_wr_data;
			end
			if (take) begin
				// Clear the running totals after the last reference of a string.
				faults_q   <= res.eos ? '0 : faults_n;
				hits_q     <= res.eos ? '0 : hits_n;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Hold the result payload until its transfer.
	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata_q <= {hits_n, faults_n, res.ev_page};
			m_tuser_q <= {res.ev_valid, res.hit};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire
